### sv/utf8d_pkg.sv
`default_nettype none
package utf8d_pkg;

  localparam int unsigned CpWidth   = 31;
  localparam int unsigned ContBits  = 6;
  localparam logic [3:0]  MaxSeqLen = 4'd6;
  localparam logic [3:0]  LenAscii  = 4'd0;
  localparam logic [3:0]  LenStray  = 4'd1;

  typedef struct packed {
    logic [2:0]         remaining;
    logic [CpWidth-1:0] partial;
    logic               halted;
  } utf8d_state_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               decode_error;
  } utf8d_result_t;

  // number of leading ones in a byte, 0..8
  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       stop;
    n    = 4'd0;
    stop = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!stop && b[i]) begin
        n = n + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### sv/utf8_stream_decoder_unit.sv
// path: an accepted byte is held in the input register, then decoded and written to
//   the result queue once it has room; a completed code point is offered from the queue
// throughput: one byte per cycle while the result queue has room, set by the single
//   decode pass between input register and the two-entry result queue
// reset: rst is synchronous, active high; clears decoder state, input stage and queue
`default_nettype none
module utf8_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  // byte side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // string_end
  // code point side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [30:0] code_point, [31] zero fill
  output logic        m_tuser    // decode_error
);
  import utf8d_pkg::*;

  // input register stage
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;

  // decoder state carried between bytes
  utf8d_state_t  state;
  utf8d_state_t  state_next;

  logic          step_valid;
  utf8d_result_t step_result;
  utf8d_result_t q_result;

  logic          room;
  logic          advance;
  logic [1:0]    q_count;

  // the input stage moves on only when the queue can take a possible result
  assign advance  = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  utf8d_step u_step (
    .state        (state),
    .data_byte    (in_byte),
    .string_end   (in_last),
    .state_next   (state_next),
    .result_valid (step_valid),
    .result       (step_result)
  );

  // state updates only when a byte is actually consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  utf8d_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && step_valid),
    .push_data (step_result),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_result),
    .count     (q_count)
  );

  assign m_tdata = {1'b0, q_result.code_point};
  assign m_tuser = q_result.decode_error;

  // an error result never carries a value
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[30:0] == 31'd0))
    else $error("error result with nonzero code point");

  // result queue never overflows
  assert property (@(posedge clk) disable iff (rst) q_count != 2'd3)
    else $error("result queue count out of range");

  // a held byte in the input stage is not lost while the queue is full
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !room) |=> in_valid)
    else $error("input stage dropped a stalled byte");

  // after a string end is consumed the decoder is back to idle
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (state == '0))
    else $error("state not cleared after string end");

endmodule
`default_nettype wire

### sv/utf8d_step.sv
`default_nettype none
module utf8d_step (
  input  utf8d_pkg::utf8d_state_t  state,
  input  logic [7:0]               data_byte,
  input  logic                     string_end,
  output utf8d_pkg::utf8d_state_t  state_next,
  output logic                     result_valid,
  output utf8d_pkg::utf8d_result_t result
);
  import utf8d_pkg::*;

  logic [3:0] len;
  logic [7:0] lead_mask;
  logic [CpWidth-1:0] shifted;

  assign len       = lead_ones(data_byte);
  assign lead_mask = 8'hFF >> len;
  assign shifted   = {state.partial[CpWidth-ContBits-1:0], data_byte[ContBits-1:0]};

  always_comb begin
    state_next   = state;
    result_valid = 1'b0;
    result       = '0;
    if (state.halted) begin
      // drop bytes until end of string
    end else if (state.remaining != 3'd0) begin
      state_next.partial   = shifted;
      state_next.remaining = state.remaining - 3'd1;
      if (state.remaining == 3'd1) begin
        result_valid      = 1'b1;
        result.code_point = shifted;
      end
    end else if (len == LenAscii || len == LenStray) begin
      result_valid      = 1'b1;
      result.code_point = {{(CpWidth-7){1'b0}}, data_byte[6:0]};
    end else if (len <= MaxSeqLen) begin
      state_next.partial   = {{(CpWidth-8){1'b0}}, data_byte & lead_mask};
      state_next.remaining = len[2:0] - 3'd1;
    end else begin
      result_valid        = 1'b1;
      result.decode_error = 1'b1;
      state_next.halted   = 1'b1;
    end
    if (string_end) begin
      state_next = '0;
    end
  end

endmodule
`default_nettype wire

### sv/utf8d_out_buf.sv
`default_nettype none
module utf8d_out_buf (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  utf8d_pkg::utf8d_result_t push_data,
  output logic                     room,
  output logic                     out_valid,
  input  logic                     out_ready,
  output utf8d_pkg::utf8d_result_t out_data,
  output logic [1:0]               count
);
  import utf8d_pkg::*;

  utf8d_result_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic          pop;

  assign out_valid = (count != 2'd0);
  assign room      = (count != 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire
